/* hw/rtl/crt_pkg.sv */
// Shared constants, codes and packing widths for the command reply tracker.
package crt_pkg;

  localparam int BufDepth = 128;
  localparam int AddrW    = $clog2(BufDepth);

  // Stream payload widths; the data words are padded to whole bytes.
  localparam int InDataW  = 40;
  localparam int InUserW  = 3;
  localparam int OutDataW = 48;

  localparam int CfgAddrW = 4;

  typedef enum logic [2:0] {
    OP_ISSUE      = 3'd0,
    OP_RX_BYTE    = 3'd1,
    OP_TICK       = 3'd2,
    OP_READ_BUF   = 3'd3,
    OP_READ_CTR   = 3'd4,
    OP_CLEAR_HLTH = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_MISSING   = 3'd2,
    ST_NAK       = 3'd3,
    ST_WRITE_ERR = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    HL_UNKNOWN = 2'd0,
    HL_OK      = 2'd1,
    HL_WARNING = 2'd2,
    HL_ERROR   = 2'd3
  } health_t;

  localparam logic [6:0] CTR_COMMAND_TOTAL  = 7'd0;
  localparam logic [6:0] CTR_ERROR_TOTAL    = 7'd1;
  localparam logic [6:0] CTR_SENT_COMMANDS  = 7'd2;
  localparam logic [6:0] CTR_SENT_BYTES     = 7'd3;
  localparam logic [6:0] CTR_WRITE_ERRORS   = 7'd4;
  localparam logic [6:0] CTR_NAK_ERRORS     = 7'd5;
  localparam logic [6:0] CTR_TIMEOUT_ERRORS = 7'd6;
  localparam logic [6:0] CTR_MISSING_ERRORS = 7'd7;
  localparam logic [6:0] CTR_EXTRA_EVENTS   = 7'd8;

  localparam logic [CfgAddrW-1:0] REG_ACK_CODE      = 4'h0;
  localparam logic [CfgAddrW-1:0] REG_NAK_CODE      = 4'h4;
  localparam logic [CfgAddrW-1:0] REG_TIMEOUT_TICKS = 4'h8;

  localparam logic [7:0]  AckCodeReset      = 8'd6;
  localparam logic [7:0]  NakCodeReset      = 8'd21;
  localparam logic [31:0] TimeoutTicksReset = 32'd1000;

endpackage

/* hw/rtl/command_reply_tracker_core.sv */
// Command reply tracker: classifies display replies, buffers data, keeps error counters.
// A result passes through the middle stage and then the output register to the master side.
// Throughput: one transaction per cycle while the master side keeps taking results.
// The reply buffer read and the counter snapshot are registered, then the health grade
// is formed from the snapshot in front of the output register.
// Reset (rst, synchronous, active high) clears all counters, flags and valids and
// restores the register defaults; the reply buffer is not cleared.
module command_reply_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: command_length[7:0], write_ok, expect_reply, expected_length[7:0],
  // rx_byte[7:0], index[6:0], zero padding
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [crt_pkg::InDataW-1:0]   s_tdata,
  // s_tuser: opcode[2:0]
  input  logic [crt_pkg::InUserW-1:0]   s_tuser,
  // m_tdata: done_res, status[2:0], received_count[7:0], health[1:0],
  // read_value[31:0], zero padding
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [crt_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crt_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import crt_pkg::*;

  // Configuration registers
  logic [7:0]  ack_code;
  logic [7:0]  nak_code;
  logic [31:0] timeout_ticks;

  // Tracker state
  logic        waiting, waiting_next;
  logic        ack_seen, ack_seen_next;
  logic        nak_seen, nak_seen_next;
  logic [7:0]  data_count, data_count_next;
  logic [7:0]  wanted_length, wanted_length_next;
  logic [31:0] time_left, time_left_next;
  logic [31:0] command_total, command_total_next;
  logic [31:0] error_total, error_total_next;
  logic [31:0] sent_commands, sent_commands_next;
  logic [31:0] sent_bytes, sent_bytes_next;
  logic [31:0] write_errors, write_errors_next;
  logic [31:0] nak_errors, nak_errors_next;
  logic [31:0] timeout_errors, timeout_errors_next;
  logic [31:0] missing_errors, missing_errors_next;
  logic [31:0] extra_events, extra_events_next;

  logic [7:0]  reply_buffer [BufDepth];
  logic [7:0]  buf_q;

  // Unpacked input fields
  opcode_t     opcode;
  logic [7:0]  command_length;
  logic        write_ok;
  logic        expect_reply;
  logic [7:0]  expected_length;
  logic [7:0]  rx_byte;
  logic [6:0]  index;

  logic        accept;
  logic        buf_wr;
  logic        buf_rd;
  logic        close_req;
  logic        done_next;
  status_t     status_next;
  logic [31:0] ctr_value;

  // Middle stage
  logic        p_valid;
  logic        p_done;
  status_t     p_status;
  logic [7:0]  p_count;
  logic [31:0] p_ctr;
  logic        p_buf;
  logic [31:0] p_err;
  logic [31:0] p_cmd;
  logic        p_ready;
  logic        o_ready;

  logic [38:0] err_x100;
  logic [38:0] err_x20;
  logic [38:0] cmd_ext;
  health_t     health;
  logic [31:0] read_value;

  assign opcode          = opcode_t'(s_tuser);
  assign command_length  = s_tdata[7:0];
  assign write_ok        = s_tdata[8];
  assign expect_reply    = s_tdata[9];
  assign expected_length = s_tdata[17:10];
  assign rx_byte         = s_tdata[25:18];
  assign index           = s_tdata[32:26];

  assign o_ready  = !m_tvalid || m_tready;
  assign p_ready  = !p_valid || o_ready;
  assign s_tready = p_ready;
  assign accept   = s_tvalid && s_tready;

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      REG_ACK_CODE:      prdata = {24'd0, ack_code};
      REG_NAK_CODE:      prdata = {24'd0, nak_code};
      REG_TIMEOUT_TICKS: prdata = timeout_ticks;
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code      <= AckCodeReset;
      nak_code      <= NakCodeReset;
      timeout_ticks <= TimeoutTicksReset;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        REG_ACK_CODE:      ack_code      <= pwdata[7:0];
        REG_NAK_CODE:      nak_code      <= pwdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  // Next-state logic for one transaction
  always_comb begin
    waiting_next        = waiting;
    ack_seen_next       = ack_seen;
    nak_seen_next       = nak_seen;
    data_count_next     = data_count;
    wanted_length_next  = wanted_length;
    time_left_next      = time_left;
    command_total_next  = command_total;
    error_total_next    = error_total;
    sent_commands_next  = sent_commands;
    sent_bytes_next     = sent_bytes;
    write_errors_next   = write_errors;
    nak_errors_next     = nak_errors;
    timeout_errors_next = timeout_errors;
    missing_errors_next = missing_errors;
    extra_events_next   = extra_events;
    done_next           = 1'b0;
    status_next         = ST_OK;
    close_req           = 1'b0;
    buf_wr              = 1'b0;

    case (opcode)
      OP_ISSUE: begin
        ack_seen_next      = 1'b0;
        nak_seen_next      = 1'b0;
        data_count_next    = 8'd0;
        wanted_length_next = expected_length;
        waiting_next       = 1'b0;
        if (command_length != 8'd0 && !write_ok) begin
          write_errors_next = write_errors + 32'd1;
          error_total_next  = error_total + 32'd1;
          done_next         = 1'b1;
          status_next       = ST_WRITE_ERR;
        end else begin
          command_total_next = command_total + 32'd1;
          sent_commands_next = sent_commands + 32'd1;
          sent_bytes_next    = sent_bytes + {24'd0, command_length};
          if (!expect_reply) begin
            done_next = 1'b1;
          end else begin
            waiting_next   = 1'b1;
            time_left_next = timeout_ticks;
          end
        end
      end
      OP_RX_BYTE: begin
        // A byte matching both codes counts as ACK.
        if (rx_byte == ack_code) begin
          ack_seen_next = 1'b1;
          close_req     = waiting && (wanted_length == 8'd0);
        end else if (rx_byte == nak_code) begin
          nak_seen_next = 1'b1;
          close_req     = waiting;
        end else if (32'(data_count) < 32'(BufDepth)) begin
          buf_wr          = 1'b1;
          data_count_next = data_count + 8'd1;
          close_req       = waiting && (data_count_next == wanted_length);
        end
      end
      OP_TICK: begin
        if (waiting) begin
          if (time_left <= 32'd1) begin
            time_left_next = 32'd0;
            close_req      = 1'b1;
          end else begin
            time_left_next = time_left - 32'd1;
          end
        end
      end
      OP_CLEAR_HLTH: begin
        command_total_next = 32'd0;
        error_total_next   = 32'd0;
      end
      default: ;
    endcase

    if (close_req) begin
      done_next    = 1'b1;
      waiting_next = 1'b0;
      if (ack_seen_next) begin
        if (wanted_length == 8'd0 || data_count_next == wanted_length) begin
          status_next = ST_OK;
        end else if (data_count_next < wanted_length) begin
          error_total_next    = error_total + 32'd1;
          missing_errors_next = missing_errors + 32'd1;
          status_next         = ST_MISSING;
        end else begin
          extra_events_next = extra_events + 32'd1;
          status_next       = ST_OK;
        end
      end else if (nak_seen_next) begin
        error_total_next = error_total + 32'd1;
        nak_errors_next  = nak_errors + 32'd1;
        status_next      = ST_NAK;
      end else begin
        error_total_next    = error_total + 32'd1;
        timeout_errors_next = timeout_errors + 32'd1;
        status_next         = ST_TIMEOUT;
      end
    end
  end

  always_comb begin
    case (index)
      CTR_COMMAND_TOTAL:  ctr_value = command_total;
      CTR_ERROR_TOTAL:    ctr_value = error_total;
      CTR_SENT_COMMANDS:  ctr_value = sent_commands;
      CTR_SENT_BYTES:     ctr_value = sent_bytes;
      CTR_WRITE_ERRORS:   ctr_value = write_errors;
      CTR_NAK_ERRORS:     ctr_value = nak_errors;
      CTR_TIMEOUT_ERRORS: ctr_value = timeout_errors;
      CTR_MISSING_ERRORS: ctr_value = missing_errors;
      CTR_EXTRA_EVENTS:   ctr_value = extra_events;
      default:            ctr_value = 32'd0;
    endcase
  end

  assign buf_rd = accept && (opcode == OP_READ_BUF) && (32'(index) < 32'(BufDepth));

  // Reply buffer
  always_ff @(posedge clk) begin
    if (accept && buf_wr) begin
      reply_buffer[data_count[AddrW-1:0]] <= rx_byte;
    end
    if (buf_rd) begin
      buf_q <= reply_buffer[index[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting        <= 1'b0;
      ack_seen       <= 1'b0;
      nak_seen       <= 1'b0;
      data_count     <= 8'd0;
      wanted_length  <= 8'd0;
      time_left      <= 32'd0;
      command_total  <= 32'd0;
      error_total    <= 32'd0;
      sent_commands  <= 32'd0;
      sent_bytes     <= 32'd0;
      write_errors   <= 32'd0;
      nak_errors     <= 32'd0;
      timeout_errors <= 32'd0;
      missing_errors <= 32'd0;
      extra_events   <= 32'd0;
    end else if (accept) begin
      waiting        <= waiting_next;
      ack_seen       <= ack_seen_next;
      nak_seen       <= nak_seen_next;
      data_count     <= data_count_next;
      wanted_length  <= wanted_length_next;
      time_left      <= time_left_next;
      command_total  <= command_total_next;
      error_total    <= error_total_next;
      sent_commands  <= sent_commands_next;
      sent_bytes     <= sent_bytes_next;
      write_errors   <= write_errors_next;
      nak_errors     <= nak_errors_next;
      timeout_errors <= timeout_errors_next;
      missing_errors <= missing_errors_next;
      extra_events   <= extra_events_next;
    end
  end

  // Middle stage holds the result fields and a snapshot of the two health counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (o_ready) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_done   <= done_next;
      p_status <= status_next;
      p_count  <= data_count_next;
      p_ctr    <= (opcode == OP_READ_CTR) ? ctr_value : 32'd0;
      p_buf    <= buf_rd;
      p_err    <= error_total_next;
      p_cmd    <= command_total_next;
    end
  end

  // Health grade: error*100 < commands is ok, error*20 < commands is a warning.
  assign err_x100 = ({7'd0, p_err} << 6) + ({7'd0, p_err} << 5) + ({7'd0, p_err} << 2);
  assign err_x20  = ({7'd0, p_err} << 4) + ({7'd0, p_err} << 2);
  assign cmd_ext  = {7'd0, p_cmd};

  always_comb begin
    if (p_cmd == 32'd0) begin
      health = HL_UNKNOWN;
    end else if (err_x100 < cmd_ext) begin
      health = HL_OK;
    end else if (err_x20 < cmd_ext) begin
      health = HL_WARNING;
    end else begin
      health = HL_ERROR;
    end
  end

  assign read_value = p_buf ? {24'd0, buf_q} : p_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_ready) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && p_valid) begin
      m_tdata <= {2'd0, read_value, health, p_count, p_status, p_done};
    end
  end

`ifndef ASSERT_OFF
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(data_count) <= 32'(BufDepth))
    else $error("data count exceeds buffer depth");

  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:1] == ST_OK))
    else $error("nonzero status on a result that closed nothing");

  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !o_ready) |=> p_valid)
    else $error("middle stage lost a result while the output stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !p_valid |-> s_tready)
    else $error("input refused with an empty middle stage");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the command reply tracker core: stream stimulus, APB setup.
`timescale 1ns / 1ps

module tb_top;
  import crt_pkg::*;

  localparam logic [2:0] OP_RESERVED = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] clen;
    logic       wok;
    logic       want;
    logic [7:0] elen;
    logic [7:0] rx;
    logic [6:0] idx;
  } link_item_t;

  typedef struct packed {
    logic        done;
    status_t     status;
    logic [7:0]  count;
    health_t     health;
    logic [31:0] rv;
  } reply_t;

  typedef struct {
    link_item_t item;
    bit         typed;
    reply_t     reply;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  command_reply_tracker_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Tracker state as the testbench sees it.
  logic [7:0]  ack_c;
  logic [7:0]  nak_c;
  logic [31:0] tmo_ticks;
  bit          in_wait;
  bit          got_ack;
  bit          got_nak;
  logic [7:0]  rx_count;
  logic [7:0]  want_len;
  logic [31:0] ticks_left;
  logic [7:0]  buf_mem[BufDepth];
  bit          buf_valid[BufDepth];
  logic [31:0] ctr[9];
  int          close_tally[5];

  reply_t      replies_due[$];
  link_item_t  link_plan[$];
  dir_row_t    dir_rows[$];
  int          errors;
  int          items_sent;
  int          replies_checked;
  bit          send_burst;
  bit          recv_burst;

  function automatic status_t close_wait();
    in_wait = 1'b0;
    if (got_ack) begin
      if (want_len == 0 || rx_count == want_len) return ST_OK;
      if (rx_count < want_len) begin
        ctr[CTR_ERROR_TOTAL]++;
        ctr[CTR_MISSING_ERRORS]++;
        return ST_MISSING;
      end
      ctr[CTR_EXTRA_EVENTS]++;
      return ST_OK;
    end
    ctr[CTR_ERROR_TOTAL]++;
    if (got_nak) begin
      ctr[CTR_NAK_ERRORS]++;
      return ST_NAK;
    end
    ctr[CTR_TIMEOUT_ERRORS]++;
    return ST_TIMEOUT;
  endfunction

  function automatic health_t grade_health();
    logic [63:0] e;
    logic [63:0] c;
    e = ctr[CTR_ERROR_TOTAL];
    c = ctr[CTR_COMMAND_TOTAL];
    if (c == 0) return HL_UNKNOWN;
    if (e * 64'd100 < c) return HL_OK;
    if (e * 64'd20 < c) return HL_WARNING;
    return HL_ERROR;
  endfunction

  function automatic reply_t track_item(link_item_t it);
    reply_t r;
    r = '0;
    case (it.op)
      OP_ISSUE: begin
        got_ack  = 1'b0;
        got_nak  = 1'b0;
        rx_count = '0;
        want_len = it.elen;
        in_wait  = 1'b0;
        if (it.clen != 0 && !it.wok) begin
          ctr[CTR_WRITE_ERRORS]++;
          ctr[CTR_ERROR_TOTAL]++;
          r.done   = 1'b1;
          r.status = ST_WRITE_ERR;
        end else begin
          ctr[CTR_COMMAND_TOTAL]++;
          ctr[CTR_SENT_COMMANDS]++;
          ctr[CTR_SENT_BYTES] += it.clen;
          if (!it.want) begin
            r.done = 1'b1;
          end else begin
            in_wait    = 1'b1;
            ticks_left = tmo_ticks;
          end
        end
      end
      OP_RX_BYTE: begin
        // ACK wins when both codes are set to the same value.
        if (it.rx == ack_c) begin
          got_ack = 1'b1;
          if (in_wait && want_len == 0) begin
            r.done   = 1'b1;
            r.status = close_wait();
          end
        end else if (it.rx == nak_c) begin
          got_nak = 1'b1;
          if (in_wait) begin
            r.done   = 1'b1;
            r.status = close_wait();
          end
        end else if (rx_count < BufDepth) begin
          buf_mem[rx_count]   = it.rx;
          buf_valid[rx_count] = 1'b1;
          rx_count++;
          if (in_wait && rx_count == want_len) begin
            r.done   = 1'b1;
            r.status = close_wait();
          end
        end
      end
      OP_TICK: begin
        if (in_wait) begin
          if (ticks_left <= 1) begin
            ticks_left = '0;
            r.done     = 1'b1;
            r.status   = close_wait();
          end else begin
            ticks_left--;
          end
        end
      end
      OP_READ_BUF: r.rv = buf_mem[it.idx];
      OP_READ_CTR: begin
        if (it.idx <= CTR_EXTRA_EVENTS) r.rv = ctr[it.idx];
      end
      OP_CLEAR_HLTH: begin
        ctr[CTR_COMMAND_TOTAL] = '0;
        ctr[CTR_ERROR_TOTAL]   = '0;
      end
      default: ;
    endcase
    r.count  = rx_count;
    r.health = grade_health();
    if (r.done) close_tally[r.status]++;
    return r;
  endfunction

  function automatic link_item_t item_of(logic [2:0] op);
    link_item_t it;
    it.op   = op;
    it.clen = 8'($urandom_range(0, 255));
    it.wok  = 1'($urandom_range(0, 1));
    it.want = 1'($urandom_range(0, 1));
    it.elen = 8'($urandom_range(0, 255));
    it.rx   = 8'($urandom_range(0, 255));
    it.idx  = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic link_item_t mk(logic [2:0] op, logic [7:0] clen, logic wok, logic want,
                                    logic [7:0] elen, logic [7:0] rx, logic [6:0] idx);
    link_item_t it;
    it.op   = op;
    it.clen = clen;
    it.wok  = wok;
    it.want = want;
    it.elen = elen;
    it.rx   = rx;
    it.idx  = idx;
    return it;
  endfunction

  function automatic reply_t mk_reply(logic done, status_t status, logic [7:0] count,
                                      health_t health, logic [31:0] rv);
    reply_t r;
    r.done   = done;
    r.status = status;
    r.count  = count;
    r.health = health;
    r.rv     = rv;
    return r;
  endfunction

  function automatic void add_row(link_item_t it, bit typed, reply_t r);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.reply = r;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ack_c || b == nak_c);
    return b;
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void plan_rx(logic [7:0] b);
    link_item_t it;
    it    = item_of(OP_RX_BYTE);
    it.rx = b;
    link_plan.push_back(it);
  endfunction

  // One command with a reply shaped to end in a chosen way: ok, missing, NAK or timeout.
  function automatic void plan_command();
    link_item_t it;
    int outcome;
    int n_data;
    int ack_at;
    int n_ticks;
    it      = item_of(OP_ISSUE);
    it.wok  = ($urandom_range(0, 9) != 0);
    it.want = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 19))
      0:       it.elen = 8'd128;
      1:       it.elen = 8'($urandom_range(129, 255));
      2, 3:    it.elen = 8'($urandom_range(7, 127));
      default: it.elen = 8'($urandom_range(0, 6));
    endcase
    link_plan.push_back(it);
    outcome = $urandom_range(0, 3);
    n_data  = (outcome == 0) ? it.elen : $urandom_range(0, it.elen);
    if (n_data > 12) n_data = $urandom_range(0, 12);
    ack_at  = $urandom_range(0, n_data);
    for (int k = 0; k <= n_data; k++) begin
      if (k == ack_at && outcome <= 1) plan_rx(ack_c);
      if (k < n_data) plan_rx(data_byte());
      if ($urandom_range(0, 5) == 0) link_plan.push_back(item_of(OP_TICK));
      if ($urandom_range(0, 9) == 0) link_plan.push_back(item_of(OP_READ_BUF));
    end
    if (outcome == 1 || outcome == 2) plan_rx(nak_c);
    if (outcome == 3) begin
      n_ticks = (tmo_ticks <= 20) ? tmo_ticks + 1 : $urandom_range(1, 5);
      repeat (n_ticks) link_plan.push_back(item_of(OP_TICK));
    end
  endfunction

  function automatic void plan_noise();
    link_item_t it;
    it = item_of(3'($urandom_range(0, 7)));
    if (it.op == OP_READ_CTR && $urandom_range(0, 4) != 0) it.idx = 7'($urandom_range(0, 9));
    link_plan.push_back(it);
  endfunction

  // Fills the whole buffer with more bytes than it holds under an oversize expected length.
  function automatic void plan_fill();
    link_item_t it;
    it      = item_of(OP_ISSUE);
    it.wok  = 1'b1;
    it.want = 1'b1;
    it.elen = 8'd255;
    link_plan.push_back(it);
    repeat (BufDepth + 2) plan_rx(data_byte());
    plan_rx(ack_c);
    plan_rx(nak_c);
    it     = item_of(OP_READ_BUF);
    it.idx = 7'(BufDepth - 1);
    link_plan.push_back(it);
  endfunction

  task automatic drive_item(input link_item_t it, input bit typed, input reply_t typed_reply);
    int gap;
    reply_t r;
    // Buffer reads only touch entries that have been filled at least once.
    if (it.op == OP_READ_BUF && !buf_valid[it.idx]) begin
      for (int k = 1; k < BufDepth; k++) begin
        if (buf_valid[(it.idx + k) % BufDepth]) begin
          it.idx = 7'((it.idx + k) % BufDepth);
          break;
        end
      end
    end
    gap = draw_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {7'd0, it.idx, it.rx, it.elen, it.want, it.wok, it.clen};
    s_tuser  <= it.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    r = track_item(it);
    replies_due.push_back(typed ? typed_reply : r);
    items_sent++;
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      REG_ACK_CODE:      ack_c     = value[7:0];
      REG_NAK_CODE:      nak_c     = value[7:0];
      REG_TIMEOUT_TICKS: tmo_ticks = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_reply(input logic [OutDataW-1:0] d);
    reply_t e;
    if (replies_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, expected none actual %h", $time, d);
    end else begin
      e = replies_due.pop_front();
      report_field("done_res", e.done, d[0]);
      report_field("status", e.status, d[3:1]);
      report_field("received_count", e.count, d[11:4]);
      report_field("health", e.health, d[13:12]);
      report_field("read_value", e.rv, d[45:14]);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold that fills the pipeline.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      gap = (replies_checked == HOLD_AT) ? HOLD_CYCLES : draw_gap(recv_burst);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_reply(m_tdata);
      replies_checked++;
    end
  end

  initial begin
    reply_t blank;
    logic [7:0] code;
    int start;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    blank    = '0;
    errors   = 0;
    items_sent      = 0;
    replies_checked = 0;
    ack_c     = AckCodeReset;
    nak_c     = NakCodeReset;
    tmo_ticks = TimeoutTicksReset;
    in_wait   = 1'b0;
    got_ack   = 1'b0;
    got_nak   = 1'b0;
    rx_count  = '0;
    want_len  = '0;
    ticks_left = '0;
    foreach (buf_mem[k]) begin
      buf_mem[k]   = '0;
      buf_valid[k] = 1'b0;
    end
    foreach (ctr[k]) ctr[k] = '0;
    foreach (close_tally[k]) close_tally[k] = 0;

    // Directed rows under the reset register values.
    add_row(mk(OP_READ_CTR, 0, 0, 0, 0, 0, CTR_COMMAND_TOTAL), 1,
            mk_reply(0, ST_OK, 0, HL_UNKNOWN, 0));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, mk_reply(0, ST_OK, 0, HL_UNKNOWN, 0));
    add_row(mk(OP_ISSUE, 8'hFF, 0, 1, 8'd128, 0, 0), 1,
            mk_reply(1, ST_WRITE_ERR, 0, HL_UNKNOWN, 0));
    add_row(mk(OP_READ_CTR, 0, 0, 0, 0, 0, CTR_WRITE_ERRORS), 1,
            mk_reply(0, ST_OK, 0, HL_UNKNOWN, 1));
    add_row(mk(OP_ISSUE, 0, 0, 0, 0, 0, 0), 0, blank);
    add_row(mk(OP_ISSUE, 3, 1, 1, 0, 0, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, AckCodeReset, 0), 0, blank);
    add_row(mk(OP_ISSUE, 5, 1, 1, 2, 0, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, 8'h00, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, 8'hFF, 0), 0, blank);
    add_row(mk(OP_ISSUE, 1, 1, 1, 3, 0, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, 8'h5A, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, AckCodeReset, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, NakCodeReset, 0), 0, blank);
    add_row(mk(OP_ISSUE, 2, 1, 1, 4, 0, 0), 0, blank);
    add_row(mk(OP_ISSUE, 8'hFF, 1, 1, 1, 0, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, NakCodeReset, 0), 0, blank);
    add_row(mk(OP_RX_BYTE, 0, 0, 0, 0, 8'hA5, 0), 0, blank);
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, blank);
    add_row(mk(OP_READ_BUF, 0, 0, 0, 0, 0, 0), 0, blank);
    add_row(mk(OP_READ_CTR, 0, 0, 0, 0, 0, 7'd127), 0, blank);
    add_row(mk(OP_READ_CTR, 0, 0, 0, 0, 0, CTR_ERROR_TOTAL), 0, blank);
    add_row(mk(OP_RESERVED, 8'hFF, 1, 1, 8'hFF, 8'hFF, 7'h7F), 0, blank);
    add_row(mk(OP_CLEAR_HLTH, 0, 0, 0, 0, 0, 0), 0, blank);
    add_row(mk(OP_READ_CTR, 0, 0, 0, 0, 0, CTR_SENT_BYTES), 0, blank);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) drive_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].reply);

    for (int phase = 0; phase < 5; phase++) begin
      drain_replies();
      code = 8'($urandom_range(0, 255));
      case (phase)
        0: begin
          apb_write(REG_ACK_CODE, 32'h0);
          apb_write(REG_NAK_CODE, 32'hFF);
          apb_write(REG_TIMEOUT_TICKS, 32'd1);
        end
        1: begin
          apb_write(REG_ACK_CODE, 32'hFF);
          apb_write(REG_NAK_CODE, 32'h0);
          apb_write(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        end
        2: begin
          // Same byte for both codes; a zero timeout closes on the first tick.
          apb_write(REG_ACK_CODE, {24'd0, code});
          apb_write(REG_NAK_CODE, {24'd0, code});
          apb_write(REG_TIMEOUT_TICKS, 32'd0);
        end
        default: begin
          apb_write(REG_ACK_CODE, $urandom());
          apb_write(REG_NAK_CODE, $urandom());
          apb_write(REG_TIMEOUT_TICKS, (phase == 3) ? $urandom_range(2, 12)
                                                    : $urandom_range(13, 40));
        end
      endcase
      if (phase == 0) plan_fill();
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) plan_command();
        else plan_noise();
        while (link_plan.size() != 0) drive_item(link_plan.pop_front(), 0, blank);
      end
    end

    drain_replies();
    repeat (10) @(posedge clk);
    $display("Summary: %0d input transactions, %0d results checked over 6 register settings.",
             items_sent, replies_checked);
    $display("Closes seen: ok %0d, timeout %0d, missing %0d, NAK %0d, write error %0d.",
             close_tally[ST_OK], close_tally[ST_TIMEOUT], close_tally[ST_MISSING],
             close_tally[ST_NAK], close_tally[ST_WRITE_ERR]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
